// File: sv/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// Types, constants and helpers shared by the command list tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package clt_pkg;

    localparam int MAX_LIST_WORDS = 16;
    localparam int MAX_WORD_LEN   = 8;
    localparam int MAX_PAREN      = 4;
    localparam int HEX_MAX_DIGITS = 16;

    localparam int LIST_IDX_W = $clog2(MAX_LIST_WORDS + 1);
    localparam int DEPTH_W    = $clog2(MAX_PAREN + 2);
    localparam int CNT_W      = 5;
    localparam int CHAR_W     = 8;
    localparam int VALUE_W    = 64;
    localparam int INDEX_W    = 4;
    localparam int COUNT_W    = 5;
    localparam int ECODE_W    = 3;
    localparam int KIND_W     = 2;
    localparam int OUT_BITS   = 1 + KIND_W + VALUE_W + INDEX_W + 1 + COUNT_W + 1 + ECODE_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_OPEN    = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE   = 8'h29;
    localparam logic [CHAR_W-1:0] CH_HASH    = 8'h23;

    localparam logic [KIND_W-1:0] KIND_NAME = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEC  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HEX  = 2'd2;

    localparam logic [ECODE_W-1:0] ERR_LENGTH = 3'd0;
    localparam logic [ECODE_W-1:0] ERR_DEPTH  = 3'd1;
    localparam logic [ECODE_W-1:0] ERR_CALL   = 3'd2;
    localparam logic [ECODE_W-1:0] ERR_NUMBER = 3'd3;
    localparam logic [ECODE_W-1:0] ERR_HEX    = 3'd4;

    typedef enum logic [1:0] {
        MODE_LIST = 2'd0,
        MODE_NAME = 2'd1,
        MODE_DEC  = 2'd2,
        MODE_HEX  = 2'd3
    } parse_mode_t;

    typedef struct packed {
        parse_mode_t             mode;
        logic [VALUE_W-1:0]      acc;
        logic [CNT_W-1:0]        char_count;
        logic [DEPTH_W-1:0]      depth;
        logic [LIST_IDX_W-1:0]   list_index;
    } parser_state_t;

    typedef struct packed {
        logic                    emit;
        logic                    token_valid;
        logic [KIND_W-1:0]       token_kind;
        logic [VALUE_W-1:0]      token_value;
        logic [INDEX_W-1:0]      token_index;
        logic                    list_done;
        logic [COUNT_W-1:0]      list_count;
        logic                    error_valid;
        logic [ECODE_W-1:0]      error_code;
    } result_t;

    function automatic logic [INDEX_W-1:0] idx_to_index(input logic [LIST_IDX_W-1:0] idx);
        logic [LIST_IDX_W+INDEX_W-1:0] wide;
        wide = {{INDEX_W{1'b0}}, idx};
        return wide[INDEX_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] idx_to_count(input logic [LIST_IDX_W-1:0] idx);
        logic [LIST_IDX_W+COUNT_W-1:0] wide;
        wide = {{COUNT_W{1'b0}}, idx};
        return wide[COUNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/clt_step.sv
// ----------------------------------------------------------------------------
// clt_step
// Per-character parser step: next parser state and the result it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_step (
    input  wire logic [clt_pkg::CHAR_W-1:0] char_in,
    input  wire clt_pkg::parser_state_t     cur,
    output clt_pkg::parser_state_t          nxt,
    output clt_pkg::result_t                res
);

    logic                             digit;
    logic                             letter;
    logic                             hex_lower;
    logic                             is_end;
    logic                             list_end;
    logic                             list_full;
    logic                             idx_zero;
    logic [clt_pkg::DEPTH_W-1:0]      depth_inc;
    logic                             too_deep;
    logic [clt_pkg::CNT_W-1:0]        cnt_inc;
    logic                             name_full;
    logic                             hex_over;
    logic [3:0]                       hex_val;
    logic [clt_pkg::VALUE_W-1:0]      dec_next;
    logic [clt_pkg::VALUE_W-1:0]      name_next;
    logic [clt_pkg::LIST_IDX_W-1:0]   idx_inc;

    assign digit     = (char_in >= 8'h30) && (char_in <= 8'h39);
    assign hex_lower = (char_in >= 8'h61) && (char_in <= 8'h66);
    assign letter    = ((char_in >= 8'h61) && (char_in <= 8'h7a))
                    || ((char_in >= 8'h41) && (char_in <= 8'h5a));
    assign list_end  = (char_in == clt_pkg::CH_CLOSE)
                    || ((char_in == clt_pkg::CH_NEWLINE) && (cur.depth == '0));
    assign is_end    = (char_in == clt_pkg::CH_SPACE) || (char_in == clt_pkg::CH_CLOSE)
                    || (char_in == clt_pkg::CH_NEWLINE);
    assign list_full = cur.list_index >= clt_pkg::LIST_IDX_W'(clt_pkg::MAX_LIST_WORDS);
    assign idx_zero  = (cur.list_index == '0);
    assign depth_inc = cur.depth + clt_pkg::DEPTH_W'(1);
    assign too_deep  = depth_inc > clt_pkg::DEPTH_W'(clt_pkg::MAX_PAREN);
    assign cnt_inc   = cur.char_count + clt_pkg::CNT_W'(1);
    assign name_full = cur.char_count >= clt_pkg::CNT_W'(clt_pkg::MAX_WORD_LEN);
    assign hex_over  = cnt_inc > clt_pkg::CNT_W'(clt_pkg::HEX_MAX_DIGITS);
    assign hex_val   = digit ? char_in[3:0] : 4'(char_in[3:0] + 4'd9);
    assign dec_next  = (cur.acc << 3) + (cur.acc << 1)
                     + {{(clt_pkg::VALUE_W-4){1'b0}}, char_in[3:0]};
    assign idx_inc   = cur.list_index + clt_pkg::LIST_IDX_W'(1);

    // byte lanes of a name, first byte lowest
    always_comb begin
        name_next = cur.acc;
        for (int i = 0; i < 8; i++) begin
            if (cur.char_count[2:0] == 3'(i)) begin
                name_next[i*8 +: 8] = cur.acc[i*8 +: 8] | char_in;
            end
        end
    end

    // next parser state
    always_comb begin
        nxt = cur;
        unique case (cur.mode)
            clt_pkg::MODE_LIST: begin
                priority if (char_in == clt_pkg::CH_SPACE) begin
                    nxt = cur;
                end else if (list_end || list_full) begin
                    nxt = '0;
                end else if (letter || (digit && idx_zero)) begin
                    nxt.mode       = clt_pkg::MODE_NAME;
                    nxt.acc        = {{(clt_pkg::VALUE_W-8){1'b0}}, char_in};
                    nxt.char_count = clt_pkg::CNT_W'(1);
                end else if (digit) begin
                    nxt.mode = clt_pkg::MODE_DEC;
                    nxt.acc  = {{(clt_pkg::VALUE_W-4){1'b0}}, char_in[3:0]};
                end else if (char_in == clt_pkg::CH_OPEN) begin
                    if (too_deep) begin
                        nxt = '0;
                    end else begin
                        nxt.list_index = '0;
                        nxt.depth      = depth_inc;
                    end
                end else if (idx_zero) begin
                    nxt = '0;
                end else if (char_in == clt_pkg::CH_HASH) begin
                    nxt.mode       = clt_pkg::MODE_HEX;
                    nxt.acc        = '0;
                    nxt.char_count = '0;
                end else begin
                    nxt = cur;
                end
            end
            clt_pkg::MODE_DEC: begin
                priority if (digit) begin
                    nxt.acc = dec_next;
                end else if (is_end && !list_end) begin
                    nxt.mode       = clt_pkg::MODE_LIST;
                    nxt.list_index = idx_inc;
                end else begin
                    nxt = '0;
                end
            end
            clt_pkg::MODE_NAME: begin
                priority if (is_end && !list_end) begin
                    nxt.mode       = clt_pkg::MODE_LIST;
                    nxt.list_index = idx_inc;
                end else if (is_end || name_full) begin
                    nxt = '0;
                end else begin
                    nxt.acc        = name_next;
                    nxt.char_count = cnt_inc;
                end
            end
            clt_pkg::MODE_HEX: begin
                priority if (digit || hex_lower) begin
                    if (hex_over) begin
                        nxt = '0;
                    end else begin
                        nxt.acc        = {cur.acc[clt_pkg::VALUE_W-5:0], hex_val};
                        nxt.char_count = cnt_inc;
                    end
                end else if (is_end && !list_end) begin
                    nxt.mode       = clt_pkg::MODE_LIST;
                    nxt.list_index = idx_inc;
                end else begin
                    nxt = '0;
                end
            end
            default: nxt = '0;
        endcase
    end

    // result of this character
    always_comb begin
        res = '0;
        unique case (cur.mode)
            clt_pkg::MODE_LIST: begin
                priority if (char_in == clt_pkg::CH_SPACE) begin
                    res = '0;
                end else if (list_end) begin
                    res.emit       = 1'b1;
                    res.list_done  = 1'b1;
                    res.list_count = clt_pkg::idx_to_count(cur.list_index);
                end else if (list_full) begin
                    res.emit        = 1'b1;
                    res.error_valid = 1'b1;
                    res.error_code  = clt_pkg::ERR_LENGTH;
                end else if (letter || digit) begin
                    res = '0;
                end else if (char_in == clt_pkg::CH_OPEN) begin
                    if (too_deep) begin
                        res.emit        = 1'b1;
                        res.error_valid = 1'b1;
                        res.error_code  = clt_pkg::ERR_DEPTH;
                    end
                end else if (idx_zero) begin
                    res.emit        = 1'b1;
                    res.error_valid = 1'b1;
                    res.error_code  = clt_pkg::ERR_CALL;
                end else begin
                    res = '0;
                end
            end
            clt_pkg::MODE_DEC: begin
                priority if (digit) begin
                    res = '0;
                end else if (is_end) begin
                    res.emit        = 1'b1;
                    res.token_valid = 1'b1;
                    res.token_kind  = clt_pkg::KIND_DEC;
                end else begin
                    res.emit        = 1'b1;
                    res.error_valid = 1'b1;
                    res.error_code  = clt_pkg::ERR_NUMBER;
                end
            end
            clt_pkg::MODE_NAME: begin
                priority if (is_end) begin
                    res.emit        = 1'b1;
                    res.token_valid = 1'b1;
                    res.token_kind  = clt_pkg::KIND_NAME;
                end else if (name_full) begin
                    res.emit        = 1'b1;
                    res.error_valid = 1'b1;
                    res.error_code  = clt_pkg::ERR_LENGTH;
                end else begin
                    res = '0;
                end
            end
            clt_pkg::MODE_HEX: begin
                priority if (digit || hex_lower) begin
                    if (hex_over) begin
                        res.emit        = 1'b1;
                        res.error_valid = 1'b1;
                        res.error_code  = clt_pkg::ERR_LENGTH;
                    end
                end else if (is_end) begin
                    res.emit        = 1'b1;
                    res.token_valid = 1'b1;
                    res.token_kind  = clt_pkg::KIND_HEX;
                end else begin
                    res.emit        = 1'b1;
                    res.error_valid = 1'b1;
                    res.error_code  = clt_pkg::ERR_HEX;
                end
            end
            default: res = '0;
        endcase
        if (res.token_valid) begin
            res.token_value = cur.acc;
            res.token_index = clt_pkg::idx_to_index(cur.list_index);
            res.list_done   = list_end;
            res.list_count  = list_end ? clt_pkg::idx_to_count(idx_inc) : '0;
        end
    end

endmodule

`default_nettype wire

// File: sv/command_list_tokenizer.sv
// ----------------------------------------------------------------------------
// command_list_tokenizer
// Splits a parenthesised command line, one character per item, into tokens.
// ----------------------------------------------------------------------------
// One character is taken per item and the block accepts one item every clock
// cycle when the result side keeps up. A character is captured in an input
// register, parsed by a single stage of shallow logic against the parser
// state (mode, accumulator, character count, paren depth, list index), and
// any result is written to the output register when the parsed character
// advances, which waits while a held result is not taken. The loop that
// sets the rate is the parser state update; a decimal digit costs one 64-bit
// sum of two shifted copies of the accumulator and the digit.
// Each result item carries a finished token, a list end with its count, or
// an error code; an error or a list end returns the parser to reset state.
// ----------------------------------------------------------------------------
`default_nettype none

module command_list_tokenizer (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output      logic                               s_tready,
    input  wire logic [clt_pkg::CHAR_W-1:0]         s_tdata,    // char_in
    output      logic                               m_tvalid,
    input  wire logic                               m_tready,
    // token_valid, token_kind, token_value, token_index, list_done,
    // list_count, error_valid, error_code, zero fill
    output      logic [clt_pkg::OUT_DATA_W-1:0]     m_tdata
);

    logic                          ch_valid_reg;
    logic                          ch_valid_next;
    logic [clt_pkg::CHAR_W-1:0]    ch_reg;
    clt_pkg::parser_state_t        state_reg;
    clt_pkg::parser_state_t        state_next;
    clt_pkg::parser_state_t        step_state;
    clt_pkg::result_t              step_res;
    clt_pkg::result_t              out_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          advance;
    logic                          s_accept;

    assign advance  = ch_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !ch_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    clt_step u_step (
        .char_in (ch_reg),
        .cur     (state_reg),
        .nxt     (step_state),
        .res     (step_res)
    );

    always_comb begin
        ch_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : ch_valid_reg);
        state_next     = advance ? step_state : state_reg;
        out_valid_next = (advance && step_res.emit) ? 1'b1
                       : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ch_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            ch_valid_reg  <= ch_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ch_reg <= s_tdata;
        end
        if (advance && step_res.emit) begin
            out_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(clt_pkg::OUT_DATA_W-clt_pkg::OUT_BITS){1'b0}},
                       out_reg.error_code, out_reg.error_valid,
                       out_reg.list_count, out_reg.list_done,
                       out_reg.token_index, out_reg.token_value,
                       out_reg.token_kind, out_reg.token_valid};

endmodule

`default_nettype wire

// File: sv/clt_checker.sv
// ----------------------------------------------------------------------------
// clt_checker
// Port-level checks for the command list tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [clt_pkg::CHAR_W-1:0]      s_tdata,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [clt_pkg::OUT_DATA_W-1:0]  m_tdata
);

    logic unused_in;
    assign unused_in = s_tvalid ^ s_tready ^ (^s_tdata);

    // held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // every item says something, and an error never carries a token or list end
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] || m_tdata[71] || m_tdata[77])
                  && !(m_tdata[77] && (m_tdata[0] || m_tdata[71])))
        else $error("result item with bad flag mix");

    // token fields are zero without a token
    a_token_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[70:1] == '0)
        else $error("token fields set without token");

    // count and code zero when unused, code in range
    a_side_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[71] || m_tdata[76:72] == '0)
                  && (m_tdata[77] || m_tdata[80:78] == '0)
                  && (m_tdata[80:78] <= 3'd4))
        else $error("list count or error code out of place");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind command_list_tokenizer clt_checker u_clt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
